// ===== rtl/b64_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_pkg: shared types, constants and alphabet functions
// Beat payload structs, codec state, result group and the base64
// character map used by the encoder and decoder.
// ----------------------------------------------------------------------------
package b64_pkg;

	// ASCII codes
	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_UP_Z = 8'h5A;
	localparam logic [7:0] CH_LO_A = 8'h61;
	localparam logic [7:0] CH_LO_Z = 8'h7A;
	localparam logic [7:0] CH_DIG0 = 8'h30;
	localparam logic [7:0] CH_DIG9 = 8'h39;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_SLSH = 8'h2F;
	localparam logic [7:0] CH_PAD  = 8'h3D;

	// mode register codes
	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	// char count saturates here; a decode message needs this many chars
	localparam logic [2:0] CHAR_FULL = 3'd4;
	// deepest pad run that still counts as padding
	localparam logic [1:0] PAD_MAX   = 2'd2;
	// held-back decoded bytes
	localparam logic [1:0] HOLD_FULL = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} b64_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       out_last;
		logic       bad_input;
	} b64_out_t;

	// message state shared by both directions
	typedef struct packed {
		logic [11:0]     bit_buffer;
		logic [2:0]      bit_count;
		logic [1:0][7:0] held_bytes;
		logic [1:0]      held_count;
		logic [2:0]      char_count;
		logic [1:0]      pad_seen;
		logic            error_seen;
	} b64_state_t;

	// results caused by one input beat, slot 0 first
	typedef struct packed {
		b64_out_t [3:0] res;
		logic [2:0]     cnt;
	} b64_group_t;

	// 6-bit value to alphabet character
	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26)
			c = CH_UP_A + {2'b00, v};
		else if (v < 6'd52)
			c = CH_LO_A + {2'b00, v} - 8'd26;
		else if (v < 6'd62)
			c = CH_DIG0 + {2'b00, v} - 8'd52;
		else if (v == 6'd62)
			c = CH_PLUS;
		else
			c = CH_SLSH;
		return c;
	endfunction

	// character to {invalid, value}; invalid characters give value zero
	function automatic logic [6:0] b64_char_val(input logic [7:0] c);
		logic [7:0] d;
		logic [6:0] r;
		d = 8'h00;
		r = 7'h40;
		if (c >= CH_UP_A && c <= CH_UP_Z) begin
			d = c - CH_UP_A;
			r = {1'b0, d[5:0]};
		end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
			d = c - CH_LO_A + 8'd26;
			r = {1'b0, d[5:0]};
		end else if (c >= CH_DIG0 && c <= CH_DIG9) begin
			d = c - CH_DIG0 + 8'd52;
			r = {1'b0, d[5:0]};
		end else if (c == CH_PLUS) begin
			r = 7'd62;
		end else if (c == CH_SLSH) begin
			r = 7'd63;
		end
		return r;
	endfunction

endpackage

// ===== rtl/base64_codec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_codec: base64 encoder / decoder, standard alphabet
// Latency: the first result of a beat is offered the cycle after the beat.
// Throughput: one input beat per cycle while each beat gives at most one
//   result and dst_ready is high; otherwise the next beat waits until the
//   single output port has drained the result group register (1-4 results).
// Reset: arst_n clears mode to encode, the message state and the output.
// ----------------------------------------------------------------------------
module base64_codec (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_mode,
	input  logic              src_valid,
	output logic              src_ready,
	input  b64_pkg::b64_in_t  src_data,
	output logic              dst_valid,
	input  logic              dst_ready,
	output b64_pkg::b64_out_t dst_data
);

	logic                mode_q;
	b64_pkg::b64_state_t st_q;
	b64_pkg::b64_state_t enc_st;
	b64_pkg::b64_state_t dec_st;
	b64_pkg::b64_group_t enc_grp;
	b64_pkg::b64_group_t dec_grp;
	b64_pkg::b64_group_t grp;
	logic                free;
	logic                src_acc;

	assign cfg_ready = 1'b1;
	assign src_ready = free;
	assign src_acc   = src_valid && free;

	b64_enc u_enc (
		.st     (st_q),
		.beat   (src_data),
		.st_nxt (enc_st),
		.grp    (enc_grp)
	);

	b64_dec u_dec (
		.st     (st_q),
		.beat   (src_data),
		.st_nxt (dec_st),
		.grp    (dec_grp)
	);

	assign grp = (mode_q == b64_pkg::MODE_DEC) ? dec_grp : enc_grp;

	b64_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (src_valid && (grp.cnt != 3'd0)),
		.grp       (grp),
		.free      (free),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data)
	);

	// mode and message state; a mode write drops any message in progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= b64_pkg::MODE_ENC;
			st_q   <= '0;
		end else if (cfg_valid) begin
			mode_q <= cfg_mode;
			st_q   <= '0;
		end else if (src_acc) begin
			st_q <= (mode_q == b64_pkg::MODE_DEC) ? dec_st : enc_st;
		end
	end

	a_bits_even: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.bit_count[0])
		else $error("odd bit count in codec state");

	a_enc_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == b64_pkg::MODE_ENC) |-> (st_q.bit_count != 3'd6))
		else $error("encoder left a full group unsent");

endmodule

// ===== rtl/b64_enc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_enc: encoder step logic
// Packs one data byte into the bit buffer, emits the full 6-bit groups as
// characters and, on the last byte, the zero-filled tail group and pads.
// ----------------------------------------------------------------------------
module b64_enc (
	input  b64_pkg::b64_state_t st,
	input  b64_pkg::b64_in_t    beat,
	output b64_pkg::b64_state_t st_nxt,
	output b64_pkg::b64_group_t grp
);

	logic [11:0] bb;
	logic [2:0]  rem;
	logic [2:0]  n;
	logic [2:0]  nm1;
	logic [1:0]  pads;

	always_comb begin
		bb     = {st.bit_buffer[3:0], beat.in_byte};
		st_nxt = st;
		grp    = '0;
		n      = 3'd0;
		rem    = 3'd0;
		pads   = 2'd0;
		nm1    = 3'd0;

		// full groups out of the new bits
		case (st.bit_count)
			3'd2: begin
				grp.res[n[1:0]] = '{b64_pkg::b64_char(bb[9:4]), 1'b1, 1'b0, 1'b0};
				n   = n + 3'd1;
				rem = 3'd4;
			end
			3'd4: begin
				grp.res[n[1:0]] = '{b64_pkg::b64_char(bb[11:6]), 1'b1, 1'b0, 1'b0};
				n = n + 3'd1;
				grp.res[n[1:0]] = '{b64_pkg::b64_char(bb[5:0]), 1'b1, 1'b0, 1'b0};
				n   = n + 3'd1;
				rem = 3'd0;
			end
			default: begin
				grp.res[n[1:0]] = '{b64_pkg::b64_char(bb[7:2]), 1'b1, 1'b0, 1'b0};
				n   = n + 3'd1;
				rem = 3'd2;
			end
		endcase
		st_nxt.bit_buffer = bb;
		st_nxt.bit_count  = rem;

		// tail group, pads and end of message
		if (beat.in_last) begin
			if (rem == 3'd2) begin
				grp.res[n[1:0]] = '{b64_pkg::b64_char({bb[1:0], 4'b0000}), 1'b1, 1'b0, 1'b0};
				n    = n + 3'd1;
				pads = 2'd2;
			end else if (rem == 3'd4) begin
				grp.res[n[1:0]] = '{b64_pkg::b64_char({bb[3:0], 2'b00}), 1'b1, 1'b0, 1'b0};
				n    = n + 3'd1;
				pads = 2'd1;
			end
			if (pads != 2'd0) begin
				grp.res[n[1:0]] = '{b64_pkg::CH_PAD, 1'b1, 1'b0, 1'b0};
				n = n + 3'd1;
			end
			if (pads == 2'd2) begin
				grp.res[n[1:0]] = '{b64_pkg::CH_PAD, 1'b1, 1'b0, 1'b0};
				n = n + 3'd1;
			end
			nm1 = n - 3'd1;
			grp.res[nm1[1:0]].out_last = 1'b1;
			st_nxt = '0;
		end
		grp.cnt = n;
	end

endmodule

// ===== rtl/b64_dec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_dec: decoder step logic
// Maps one character to 6 bits, gathers whole bytes into a two-deep hold
// and, at the end of the message, releases the bytes not eaten by pads.
// ----------------------------------------------------------------------------
module b64_dec (
	input  b64_pkg::b64_state_t st,
	input  b64_pkg::b64_in_t    beat,
	output b64_pkg::b64_state_t st_nxt,
	output b64_pkg::b64_group_t grp
);

	logic [6:0]  cv;
	logic        is_pad;
	logic [5:0]  v;
	logic        err;
	logic [1:0]  ps;
	logic [2:0]  cc;
	logic [11:0] bb;
	logic        got;
	logic [7:0]  nb;
	logic [2:0]  bc;
	logic [1:0]  hc;
	logic [1:0]  keep;
	logic        bad;
	logic [2:0]  n;
	logic [2:0]  nm1;
	logic [1:0][7:0] hb;

	always_comb begin
		st_nxt = st;
		grp    = '0;
		n      = 3'd0;
		nm1    = 3'd0;
		keep   = 2'd0;
		bad    = 1'b0;
		cv     = b64_pkg::b64_char_val(beat.in_byte);
		is_pad = (beat.in_byte == b64_pkg::CH_PAD);
		err    = st.error_seen;
		ps     = st.pad_seen;
		v      = 6'd0;

		// pad tracking and character check
		if (is_pad) begin
			if (ps == b64_pkg::PAD_MAX)
				err = 1'b1;
			else
				ps = ps + 2'd1;
		end else begin
			if (cv[6])
				err = 1'b1;
			else
				v = cv[5:0];
			if (ps != 2'd0)
				err = 1'b1;
			ps = 2'd0;
		end
		cc = (st.char_count < b64_pkg::CHAR_FULL) ? st.char_count + 3'd1 : st.char_count;

		// bit gathering: a byte completes on every char but the first of four
		bb = {st.bit_buffer[5:0], v};
		case (st.bit_count)
			3'd6: begin
				got = 1'b1;
				nb  = bb[11:4];
				bc  = 3'd4;
			end
			3'd4: begin
				got = 1'b1;
				nb  = bb[9:2];
				bc  = 3'd2;
			end
			3'd2: begin
				got = 1'b1;
				nb  = bb[7:0];
				bc  = 3'd0;
			end
			default: begin
				got = 1'b0;
				nb  = 8'h00;
				bc  = 3'd6;
			end
		endcase

		// two-deep hold, oldest released when full
		hb = st.held_bytes;
		hc = st.held_count;
		if (got) begin
			if (hc == b64_pkg::HOLD_FULL) begin
				grp.res[n[1:0]] = '{hb[0], 1'b1, 1'b0, 1'b0};
				n     = n + 3'd1;
				hb[0] = hb[1];
				hb[1] = nb;
			end else begin
				hb[hc[0]] = nb;
				hc        = hc + 2'd1;
			end
		end

		st_nxt.bit_buffer = bb;
		st_nxt.bit_count  = bc;
		st_nxt.held_bytes = hb;
		st_nxt.held_count = hc;
		st_nxt.char_count = cc;
		st_nxt.pad_seen   = ps;
		st_nxt.error_seen = err;

		// end of message: drop pad bytes, or a bare marker for short text
		if (beat.in_last) begin
			if (cc == b64_pkg::CHAR_FULL) begin
				keep = (hc > ps) ? hc - ps : 2'd0;
				if (keep != 2'd0) begin
					grp.res[n[1:0]] = '{hb[0], 1'b1, 1'b0, 1'b0};
					n = n + 3'd1;
				end
				if (keep == 2'd2) begin
					grp.res[n[1:0]] = '{hb[1], 1'b1, 1'b0, 1'b0};
					n = n + 3'd1;
				end
				bad = err;
			end else begin
				n = 3'd0;
			end
			if (n == 3'd0) begin
				grp.res[0] = '{8'h00, 1'b0, 1'b0, 1'b0};
				n          = 3'd1;
			end
			nm1 = n - 3'd1;
			grp.res[nm1[1:0]].out_last  = 1'b1;
			grp.res[nm1[1:0]].bad_input = bad;
			st_nxt = '0;
		end
		grp.cnt = n;
	end

endmodule

// ===== rtl/b64_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64_out_buf: result group register and output sequencer
// Holds the results of one input beat and hands them out one beat at a
// time; a new group loads in the cycle the last result is taken.
// ----------------------------------------------------------------------------
module b64_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  b64_pkg::b64_group_t grp,
	output logic                free,
	output logic                dst_valid,
	input  logic                dst_ready,
	output b64_pkg::b64_out_t   dst_data
);

	logic                vld_q;
	logic [1:0]          idx_q;
	b64_pkg::b64_group_t grp_q;
	logic                at_end;
	logic                pop_last;

	// last slot of the held group
	assign at_end   = ({1'b0, idx_q} == (grp_q.cnt - 3'd1));
	assign pop_last = vld_q && dst_ready && at_end;
	assign free     = !vld_q || pop_last;

	assign dst_valid = vld_q;
	assign dst_data  = grp_q.res[idx_q];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= 2'd0;
		end else if (load && free) begin
			vld_q <= 1'b1;
			idx_q <= 2'd0;
		end else if (pop_last) begin
			vld_q <= 1'b0;
		end else if (vld_q && dst_ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load && free)
			grp_q <= grp;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> (grp_q.cnt != 3'd0 && grp_q.cnt <= 3'd4))
		else $error("result group count out of range");

	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> ({1'b0, idx_q} < grp_q.cnt))
		else $error("result index past group end");

	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && dst_data.out_last) |-> at_end)
		else $error("end flag before final slot of group");

	a_bad_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && dst_data.bad_input) |-> dst_data.out_last)
		else $error("bad_input on a non-final result");

endmodule
